// File: hdl/ipv4_src_dst_prefix_filter_core_macros.svh
// assertion macros shared by the prefix filter checker
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef IPV4_SRC_DST_PREFIX_FILTER_CORE_MACROS_SVH
`define IPV4_SRC_DST_PREFIX_FILTER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies a later consequent
`define IPF_ASSERT_DLY2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##2 (cons)) else $error(msg);

`endif

// File: hdl/ipf_pkg.sv
// shared types, constants and the prefix mask function of the prefix filter
// no dependencies
package ipf_pkg;

    localparam int RULES_PER_SIDE = 4;
    localparam int RULE_SLOTS     = 4;
    localparam int SLOT_W         = $clog2(RULE_SLOTS);
    localparam int NUM_REGS       = 2 * RULE_SLOTS;
    localparam int REG_IDX_W      = $clog2(NUM_REGS);
    localparam int ADDR_W         = REG_IDX_W + 3;
    localparam int DATA_W         = 64;
    localparam int ADDR_LSB       = 3;
    localparam int IP_W           = 32;
    localparam int LEN_W          = 6;
    localparam int REG_W          = 1 + LEN_W + IP_W;

    localparam logic SIDE_SRC = 1'b0;
    localparam logic SIDE_DST = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        logic [IP_W-1:0]  net;
    } t_rule;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_lane_res;

    // lengths above 32 saturate; a shift by 32 leaves all ones in the mask
    function automatic logic [IP_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] sat;
        sat = (len > LEN_W'(IP_W)) ? LEN_W'(IP_W) : len;
        return ~({IP_W{1'b1}} >> sat);
    endfunction

endpackage

// File: hdl/ipf_lane.sv
// one rule compare lane: masked address against masked network
// depends on ipf_pkg
module ipf_lane (
    input  logic [ipf_pkg::IP_W-1:0] i_addr,
    input  ipf_pkg::t_rule           i_rule,
    output ipf_pkg::t_lane_res       o_res
);
    import ipf_pkg::*;

    logic [IP_W-1:0] mask;

    assign mask        = prefix_mask(i_rule.len);
    assign o_res.valid = i_rule.valid;
    assign o_res.hit   = i_rule.valid && ((i_addr & mask) == (i_rule.net & mask));

endmodule

// File: hdl/ipf_merge.sv
// merging stage: folds lane results of both sides into the registered verdict
// depends on ipf_pkg
module ipf_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_hdr,
    input  ipf_pkg::t_lane_res i_src [ipf_pkg::RULES_PER_SIDE],
    input  ipf_pkg::t_lane_res i_dst [ipf_pkg::RULES_PER_SIDE],
    output logic              o_valid,
    output logic              o_matched
);
    import ipf_pkg::*;

    logic r_valid, n_valid;
    logic r_matched, n_matched;
    logic src_any_v, src_any_h, dst_any_v, dst_any_h;

    always_comb begin
        src_any_v = 1'b0;
        src_any_h = 1'b0;
        dst_any_v = 1'b0;
        dst_any_h = 1'b0;
        for (int i = 0; i < RULES_PER_SIDE; i++) begin
            src_any_v = src_any_v | i_src[i].valid;
            src_any_h = src_any_h | i_src[i].hit;
            dst_any_v = dst_any_v | i_dst[i].valid;
            dst_any_h = dst_any_h | i_dst[i].hit;
        end
        // a side with no valid rule passes
        n_matched = i_hdr && (!src_any_v || src_any_h) && (!dst_any_v || dst_any_h);
        n_valid   = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

    assign o_valid   = r_valid;
    assign o_matched = r_matched;

endmodule

// File: hdl/ipv4_src_dst_prefix_filter_core.sv
// top level of the ipv4 source/destination prefix filter
// depends on ipf_pkg, ipf_lane and ipf_merge
//
// usage
//   request channel: drive i_has_ipv4, i_src_addr, i_dst_addr and raise start;
//   the request is taken at a clock edge where start is high and busy is low.
//   busy is always low, so one request can be taken every cycle.
//   result channel: o_valid is high for one cycle with o_matched once the
//   request has passed the lane register and the merging stage; results
//   come back in request order. the compare lanes (one per rule and side,
//   in parallel) run into a register, then the merging stage folds them.
//   throughput is one request per cycle.
//   rules are written over the apb port, one 64-bit register per rule at byte
//   address 8*i (source rules 0..3, destination rules 4..7); writes are meant
//   to happen while no request is in flight. pready is always high.
//   synchronous reset clears all rules and the in-flight valids; no result is
//   shown until a new request is taken. the receiver cannot stall the block.
module ipv4_src_dst_prefix_filter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_has_ipv4,
    input  logic [ipf_pkg::IP_W-1:0]      i_src_addr,
    input  logic [ipf_pkg::IP_W-1:0]      i_dst_addr,
    output logic                          o_valid,
    output logic                          o_matched,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipf_pkg::ADDR_W-1:0]    paddr,
    input  logic [ipf_pkg::DATA_W-1:0]    pwdata,
    output logic [ipf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import ipf_pkg::*;

    t_rule r_src_rule [RULE_SLOTS];
    t_rule r_dst_rule [RULE_SLOTS];

    t_lane_res src_res [RULES_PER_SIDE];
    t_lane_res dst_res [RULES_PER_SIDE];
    t_lane_res r_src_res [RULES_PER_SIDE];
    t_lane_res r_dst_res [RULES_PER_SIDE];
    logic      r_v1, n_v1;
    logic      r_hdr;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_side;
    logic [SLOT_W-1:0]    reg_slot;
    t_rule                wr_rule;
    t_rule                rd_rule;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
    assign reg_side = reg_idx[REG_IDX_W-1];
    assign reg_slot = reg_idx[SLOT_W-1:0];
    assign wr_rule = t_rule'(pwdata[REG_W-1:0]);

    // rule registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RULE_SLOTS; i++) begin
                r_src_rule[i] <= '0;
                r_dst_rule[i] <= '0;
            end
        end else if (cfg_wr) begin
            if (reg_side == SIDE_SRC) begin
                r_src_rule[reg_slot] <= wr_rule;
            end else begin
                r_dst_rule[reg_slot] <= wr_rule;
            end
        end
    end

    always_comb begin
        unique case (reg_side)
            SIDE_SRC: rd_rule = r_src_rule[reg_slot];
            SIDE_DST: rd_rule = r_dst_rule[reg_slot];
            default:  rd_rule = '0;
        endcase
    end

    assign prdata = {{(DATA_W-REG_W){1'b0}}, rd_rule};

    // compare lanes
    for (genvar g = 0; g < RULES_PER_SIDE; g++) begin : g_lane
        ipf_lane u_src_lane (
            .i_addr (i_src_addr),
            .i_rule (r_src_rule[g]),
            .o_res  (src_res[g])
        );
        ipf_lane u_dst_lane (
            .i_addr (i_dst_addr),
            .i_rule (r_dst_rule[g]),
            .o_res  (dst_res[g])
        );
    end

    assign n_v1 = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= i_has_ipv4;
        for (int i = 0; i < RULES_PER_SIDE; i++) begin
            r_src_res[i] <= src_res[i];
            r_dst_res[i] <= dst_res[i];
        end
    end

    ipf_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v1),
        .i_hdr     (r_hdr),
        .i_src     (r_src_res),
        .i_dst     (r_dst_res),
        .o_valid   (o_valid),
        .o_matched (o_matched)
    );

endmodule

// File: hdl/ipf_checker.sv
// port-level checker for the prefix filter, bound to the top level
// depends on ipf_pkg and ipv4_src_dst_prefix_filter_core_macros.svh
`include "ipv4_src_dst_prefix_filter_core_macros.svh"

module ipf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_has_ipv4,
    input logic                       o_valid,
    input logic                       o_matched,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [ipf_pkg::ADDR_W-1:0] paddr,
    input logic [ipf_pkg::DATA_W-1:0] pwdata,
    input logic [ipf_pkg::DATA_W-1:0] prdata
);
    import ipf_pkg::*;

    logic             wr_now;
    logic [REG_W-1:0] rd_val;
    logic [REG_W-1:0] wr_val;

    // a write under reset is lost to the reset
    assign wr_now = i_rst_n && psel && penable && pwrite;
    assign rd_val = prdata[REG_W-1:0];
    assign wr_val = pwdata[REG_W-1:0];

    // every taken request later gives a result
    `IPF_ASSERT_DLY2(a_latency, start && !busy, o_valid, "result missing after request")

    // no result without an earlier request
    `IPF_ASSERT_NOW(a_no_extra, o_valid, $past(start && !busy, 2), "result without request")

    // a match needs a header on the request that caused it
    `IPF_ASSERT_NOW(a_hdr, o_valid && o_matched, $past(i_has_ipv4, 2), "match without header")

    // a rule write is read back on the next cycle at the same address
    `IPF_ASSERT_NOW(a_readback, $past(wr_now) && $stable(paddr), rd_val == $past(wr_val), "bad readback")

endmodule

bind ipv4_src_dst_prefix_filter_core ipf_checker u_ipf_checker (.*);
